### design/spd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// spd_pkg
// Shared types, codes and helpers of the serial packet deframer.
// ============================================================================
package spd_pkg;

    // Operation codes of an input word.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Event codes of a result word.
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_PAYLOAD   = 3'd1;
    localparam logic [2:0] EV_GOOD      = 3'd2;
    localparam logic [2:0] EV_CRC_FAIL  = 3'd3;
    localparam logic [2:0] EV_BAD_HDR   = 3'd4;
    localparam logic [2:0] EV_BAD_START = 3'd5;
    localparam logic [2:0] EV_TIMEOUT   = 3'd6;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd4;
    localparam int CFG_DATA_W = 16;

    // Register reset values.
    localparam logic [7:0]  RST_START_HIGH = 8'd2;
    localparam logic [7:0]  RST_START_LOW  = 8'd2;
    localparam logic [7:0]  RST_VERSION    = 8'd1;
    localparam logic [7:0]  RST_MAX_LENGTH = 8'd255;
    localparam logic [15:0] RST_TIMEOUT    = 16'd50;

    // Hard limit on the payload length.
    localparam logic [7:0] MAX_PAYLOAD = 8'd255;

    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [15:0] TIMER_MAX = 16'hFFFF;

    typedef logic [31:0] t_count;

    // CRC-16/CCITT, polynomial 0x1021, one byte per call, MSB first.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0]  x;
        logic [15:0] xw;
        x  = crc[15:8] ^ b;
        x  = x ^ (x >> 4);
        xw = {8'h00, x};
        return {crc[7:0], 8'h00} ^ (xw << 12) ^ (xw << 5) ^ xw;
    endfunction

endpackage

### design/spd_in_if.sv
`timescale 1ns / 1ps
// ============================================================================
// spd_in_if
// Input channel: one received byte or one timer tick per word.
// ============================================================================
interface spd_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

### design/spd_out_if.sv
`timescale 1ns / 1ps
// ============================================================================
// spd_out_if
// Result channel: event, payload byte with its position, and running counters.
// ============================================================================
interface spd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  payload_byte;
    logic [7:0]  byte_index;
    logic [7:0]  packet_length;
    logic [31:0] good_count;
    logic [31:0] bad_count;
    logic [31:0] bad_start_count;
    logic [31:0] timeout_count;

    modport source (output valid, output event_res, output payload_byte, output byte_index,
                    output packet_length, output good_count, output bad_count,
                    output bad_start_count, output timeout_count, input ready);
    modport sink   (input valid, input event_res, input payload_byte, input byte_index,
                    input packet_length, input good_count, input bad_count,
                    input bad_start_count, input timeout_count, output ready);
endinterface

### design/serial_packet_deframer_crc16_unit.sv
// A result word appears in the cycle after its input word is accepted.
// Throughput: one word per cycle while the result channel drains; the frame state and CRC update together.
// The input is taken whenever the result register is empty or being drained.
// Reset (synchronous, active low) returns to start-mark hunt with the timer stopped,
// counters cleared and the configuration registers at their defaults.
`timescale 1ns / 1ps
// ============================================================================
// serial_packet_deframer_crc16_unit
// Hunts for a two-byte start mark, checks version and length, streams payload
// bytes with their index, checks a big-endian CRC-16/CCITT and reports a verdict.
// ============================================================================
module serial_packet_deframer_crc16_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [spd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [spd_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    spd_in_if.sink                              i_in,
    spd_out_if.source                           o_out
);

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_START_LOW  = 3'd1;
    localparam logic [2:0] PH_VERSION    = 3'd2;
    localparam logic [2:0] PH_LENGTH     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD    = 3'd4;
    localparam logic [2:0] PH_CHECK_HIGH = 3'd5;
    localparam logic [2:0] PH_CHECK_LOW  = 3'd6;

    // Configuration registers.
    logic [7:0]  r_start_high, r_start_low, r_version, r_max_length;
    logic [15:0] r_timeout;

    // Frame state.
    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [7:0]  r_frame_len, n_frame_len;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_chk_high, n_chk_high;
    logic [15:0] r_timer, n_timer;
    logic        r_timer_run, n_timer_run;
    spd_pkg::t_count r_good, n_good, r_bad, n_bad, r_bad_start, n_bad_start;
    spd_pkg::t_count r_timeouts, n_timeouts;

    // Result register.
    logic        r_out_valid;
    logic [2:0]  r_ev, n_ev;
    logic [7:0]  r_pbyte, n_pbyte, r_pidx, n_pidx, r_plen, n_plen;

    logic        in_fire;
    logic [7:0]  b;
    logic [15:0] timer_inc;
    logic [15:0] got;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;
    assign b          = i_in.rx_byte;
    assign timer_inc  = (r_timer == spd_pkg::TIMER_MAX) ? r_timer : r_timer + 16'd1;
    assign got        = {r_chk_high, b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_high <= spd_pkg::RST_START_HIGH;
            r_start_low  <= spd_pkg::RST_START_LOW;
            r_version    <= spd_pkg::RST_VERSION;
            r_max_length <= spd_pkg::RST_MAX_LENGTH;
            r_timeout    <= spd_pkg::RST_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                spd_pkg::CFG_START_HIGH: r_start_high <= i_cfg_wdata[7:0];
                spd_pkg::CFG_START_LOW:  r_start_low  <= i_cfg_wdata[7:0];
                spd_pkg::CFG_VERSION:    r_version    <= i_cfg_wdata[7:0];
                spd_pkg::CFG_MAX_LENGTH: r_max_length <= i_cfg_wdata[7:0];
                spd_pkg::CFG_TIMEOUT:    r_timeout    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_bytes_left = r_bytes_left;
        n_frame_len = r_frame_len;
        n_crc       = r_crc;
        n_chk_high  = r_chk_high;
        n_timer     = r_timer;
        n_timer_run = r_timer_run;
        n_good      = r_good;
        n_bad       = r_bad;
        n_bad_start = r_bad_start;
        n_timeouts  = r_timeouts;
        n_ev        = spd_pkg::EV_NONE;
        n_pbyte     = 8'd0;
        n_pidx      = 8'd0;
        n_plen      = 8'd0;
        if (i_in.op == spd_pkg::OP_TICK) begin
            if (r_timer_run) begin
                n_timer = timer_inc;
                if (timer_inc >= r_timeout) begin
                    n_phase     = PH_IDLE;
                    n_timer_run = 1'b0;
                    n_timer     = 16'd0;
                    n_timeouts  = r_timeouts + 32'd1;
                    n_ev        = spd_pkg::EV_TIMEOUT;
                end
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (b == r_start_high) begin
                        n_phase     = PH_START_LOW;
                        n_timer_run = 1'b1;
                        n_timer     = 16'd0;
                    end else begin
                        n_bad_start = r_bad_start + 32'd1;
                        n_ev        = spd_pkg::EV_BAD_START;
                    end
                end
                PH_START_LOW: begin
                    if (b == r_start_low) begin
                        n_phase = PH_VERSION;
                    end else begin
                        n_bad_start = r_bad_start + 32'd1;
                        n_phase     = PH_IDLE;
                        n_timer_run = 1'b0;
                        n_timer     = 16'd0;
                        n_ev        = spd_pkg::EV_BAD_START;
                    end
                end
                PH_VERSION: begin
                    if (b == r_version) begin
                        n_phase = PH_LENGTH;
                    end else begin
                        n_bad       = r_bad + 32'd1;
                        n_phase     = PH_IDLE;
                        n_timer_run = 1'b0;
                        n_timer     = 16'd0;
                        n_ev        = spd_pkg::EV_BAD_HDR;
                    end
                end
                PH_LENGTH: begin
                    n_frame_len  = b;
                    n_bytes_left = b;
                    n_crc        = spd_pkg::CRC_SEED;
                    if (b != 8'd0 && b <= r_max_length && b <= spd_pkg::MAX_PAYLOAD) begin
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_bad       = r_bad + 32'd1;
                        n_phase     = PH_IDLE;
                        n_timer_run = 1'b0;
                        n_timer     = 16'd0;
                        n_ev        = spd_pkg::EV_BAD_HDR;
                        n_plen      = b;
                    end
                end
                PH_PAYLOAD: begin
                    n_ev         = spd_pkg::EV_PAYLOAD;
                    n_pbyte      = b;
                    n_pidx       = r_frame_len - r_bytes_left;
                    n_plen       = r_frame_len;
                    n_crc        = spd_pkg::crc16_update(r_crc, b);
                    n_bytes_left = r_bytes_left - 8'd1;
                    if (r_bytes_left == 8'd1) begin
                        n_phase = PH_CHECK_HIGH;
                    end
                end
                PH_CHECK_HIGH: begin
                    n_chk_high = b;
                    n_phase    = PH_CHECK_LOW;
                end
                default: begin
                    // Low checksum byte; unused phase codes land here as well.
                    n_phase     = PH_IDLE;
                    n_timer_run = 1'b0;
                    n_timer     = 16'd0;
                    n_plen      = r_frame_len;
                    if (got == r_crc) begin
                        n_good = r_good + 32'd1;
                        n_ev   = spd_pkg::EV_GOOD;
                    end else begin
                        n_bad = r_bad + 32'd1;
                        n_ev  = spd_pkg::EV_CRC_FAIL;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bytes_left <= 8'd0;
            r_frame_len  <= 8'd0;
            r_crc        <= spd_pkg::CRC_SEED;
            r_chk_high   <= 8'd0;
            r_timer      <= 16'd0;
            r_timer_run  <= 1'b0;
            r_good       <= 32'd0;
            r_bad        <= 32'd0;
            r_bad_start  <= 32'd0;
            r_timeouts   <= 32'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase      <= n_phase;
                r_bytes_left <= n_bytes_left;
                r_frame_len  <= n_frame_len;
                r_crc        <= n_crc;
                r_chk_high   <= n_chk_high;
                r_timer      <= n_timer;
                r_timer_run  <= n_timer_run;
                r_good       <= n_good;
                r_bad        <= n_bad;
                r_bad_start  <= n_bad_start;
                r_timeouts   <= n_timeouts;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ev    <= n_ev;
            r_pbyte <= n_pbyte;
            r_pidx  <= n_pidx;
            r_plen  <= n_plen;
        end
    end

    // The counters change only with an accepted word, so they always hold the
    // totals after the word shown in the result register.
    assign o_out.valid           = r_out_valid;
    assign o_out.event_res       = r_ev;
    assign o_out.payload_byte    = r_pbyte;
    assign o_out.byte_index      = r_pidx;
    assign o_out.packet_length   = r_plen;
    assign o_out.good_count      = r_good;
    assign o_out.bad_count       = r_bad;
    assign o_out.bad_start_count = r_bad_start;
    assign o_out.timeout_count   = r_timeouts;

endmodule

### design/spd_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// spd_checker
// Port-level checks on the result channel of the deframer.
// ============================================================================
module spd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_event_res,
    input logic [7:0]  i_payload_byte,
    input logic [7:0]  i_byte_index,
    input logic [7:0]  i_packet_length,
    input logic [31:0] i_good_count,
    input logic [31:0] i_timeout_count
);

    logic        out_fire;
    logic [31:0] r_last_good, r_last_timeouts;

    assign out_fire = i_out_valid && i_out_ready;

    // Totals as of the last word taken from the result channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_good     <= 32'd0;
            r_last_timeouts <= 32'd0;
        end else if (out_fire) begin
            r_last_good     <= i_good_count;
            r_last_timeouts <= i_timeout_count;
        end
    end

    a_index_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_event_res == spd_pkg::EV_PAYLOAD
            |-> i_byte_index < i_packet_length)
        else $error("payload byte index outside the packet length");

    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_event_res == spd_pkg::EV_NONE ||
                        i_event_res == spd_pkg::EV_BAD_START ||
                        i_event_res == spd_pkg::EV_TIMEOUT)
            |-> i_packet_length == 8'd0 && i_payload_byte == 8'd0 && i_byte_index == 8'd0)
        else $error("payload fields set on a word without a packet");

    a_good_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire |-> i_good_count ==
            r_last_good + ((i_event_res == spd_pkg::EV_GOOD) ? 32'd1 : 32'd0))
        else $error("good packet count does not follow the verdicts");

    a_timeout_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire |-> i_timeout_count ==
            r_last_timeouts + ((i_event_res == spd_pkg::EV_TIMEOUT) ? 32'd1 : 32'd0))
        else $error("timeout count does not follow the timeout events");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_event_res))
        else $error("stalled result word changed");

endmodule

bind serial_packet_deframer_crc16_unit spd_checker u_spd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_event_res     (o_out.event_res),
    .i_payload_byte  (o_out.payload_byte),
    .i_byte_index    (o_out.byte_index),
    .i_packet_length (o_out.packet_length),
    .i_good_count    (o_out.good_count),
    .i_timeout_count (o_out.timeout_count)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the serial packet deframer. A behavioral model
// tracks the frame state, CRC, timer and counters for every accepted word and
// queues the report it must produce; a monitor compares each report word
// field by field. Directed cases cover start mark, header, length, CRC and
// timeout handling; random framed traffic with noise follows under several
// register settings, with random gaps on both channels in all but one of them.
// ============================================================================
module tb_top;

    localparam logic [2:0] ST_HUNT_HIGH    = 3'd0;
    localparam logic [2:0] ST_HUNT_LOW     = 3'd1;
    localparam logic [2:0] ST_WAIT_VERSION = 3'd2;
    localparam logic [2:0] ST_WAIT_LENGTH  = 3'd3;
    localparam logic [2:0] ST_IN_PAYLOAD   = 3'd4;
    localparam logic [2:0] ST_CHECK_HIGH   = 3'd5;
    localparam logic [2:0] ST_CHECK_LOW    = 3'd6;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  payload_byte;
        logic [7:0]  byte_index;
        logic [7:0]  packet_length;
        logic [31:0] good_count;
        logic [31:0] bad_count;
        logic [31:0] bad_start_count;
        logic [31:0] timeout_count;
    } t_frame_report;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [spd_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [spd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata;

    spd_in_if  in_ch ();
    spd_out_if out_ch ();

    serial_packet_deframer_crc16_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #6 i_clk = ~i_clk;

    // Register copies.
    logic [7:0]  cfg_start_high = spd_pkg::RST_START_HIGH;
    logic [7:0]  cfg_start_low  = spd_pkg::RST_START_LOW;
    logic [7:0]  cfg_version    = spd_pkg::RST_VERSION;
    logic [7:0]  cfg_max_length = spd_pkg::RST_MAX_LENGTH;
    logic [15:0] cfg_timeout    = spd_pkg::RST_TIMEOUT;

    // Deframer state as the model sees it.
    logic [2:0]  rx_state    = ST_HUNT_HIGH;
    logic [7:0]  bytes_left  = '0;
    logic [7:0]  frame_len   = '0;
    logic [15:0] frame_crc   = spd_pkg::CRC_SEED;
    logic [7:0]  crc_high    = '0;
    logic [15:0] timer_ticks = '0;
    logic        timer_on    = 1'b0;
    logic [31:0] good_total = '0, bad_total = '0, bad_start_total = '0, timeout_total = '0;

    t_frame_report report_queue[$];
    int  error_count = 0;
    int  words_sent  = 0;
    bit  gaps_on     = 1'b1;

    // Bitwise CRC-16/CCITT, MSB first.
    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction

    task automatic abandon_frame();
        rx_state    = ST_HUNT_HIGH;
        timer_on    = 1'b0;
        timer_ticks = '0;
    endtask

    task automatic predict_report(input logic op, input logic [7:0] b);
        t_frame_report r;
        logic [15:0]   got;
        r = '0;
        if (op == spd_pkg::OP_TICK) begin
            if (timer_on) begin
                if (timer_ticks != spd_pkg::TIMER_MAX) timer_ticks++;
                if (timer_ticks >= cfg_timeout) begin
                    abandon_frame();
                    timeout_total++;
                    r.event_res = spd_pkg::EV_TIMEOUT;
                end
            end
        end else begin
            unique case (rx_state)
                ST_HUNT_HIGH: begin
                    if (b == cfg_start_high) begin
                        rx_state    = ST_HUNT_LOW;
                        timer_on    = 1'b1;
                        timer_ticks = '0;
                    end else begin
                        bad_start_total++;
                        r.event_res = spd_pkg::EV_BAD_START;
                    end
                end
                ST_HUNT_LOW: begin
                    if (b == cfg_start_low) begin
                        rx_state = ST_WAIT_VERSION;
                    end else begin
                        bad_start_total++;
                        abandon_frame();
                        r.event_res = spd_pkg::EV_BAD_START;
                    end
                end
                ST_WAIT_VERSION: begin
                    if (b == cfg_version) begin
                        rx_state = ST_WAIT_LENGTH;
                    end else begin
                        bad_total++;
                        abandon_frame();
                        r.event_res = spd_pkg::EV_BAD_HDR;
                    end
                end
                ST_WAIT_LENGTH: begin
                    frame_len  = b;
                    bytes_left = b;
                    frame_crc  = spd_pkg::CRC_SEED;
                    if (b != 8'd0 && b <= cfg_max_length && b <= spd_pkg::MAX_PAYLOAD) begin
                        rx_state = ST_IN_PAYLOAD;
                    end else begin
                        bad_total++;
                        abandon_frame();
                        r.event_res     = spd_pkg::EV_BAD_HDR;
                        r.packet_length = b;
                    end
                end
                ST_IN_PAYLOAD: begin
                    r.event_res     = spd_pkg::EV_PAYLOAD;
                    r.payload_byte  = b;
                    r.byte_index    = frame_len - bytes_left;
                    r.packet_length = frame_len;
                    frame_crc       = crc_ccitt_step(frame_crc, b);
                    bytes_left--;
                    if (bytes_left == 8'd0) rx_state = ST_CHECK_HIGH;
                end
                ST_CHECK_HIGH: begin
                    crc_high = b;
                    rx_state = ST_CHECK_LOW;
                end
                default: begin
                    got = {crc_high, b};
                    abandon_frame();
                    r.packet_length = frame_len;
                    if (got == frame_crc) begin
                        good_total++;
                        r.event_res = spd_pkg::EV_GOOD;
                    end else begin
                        bad_total++;
                        r.event_res = spd_pkg::EV_CRC_FAIL;
                    end
                end
            endcase
        end
        r.good_count      = good_total;
        r.bad_count       = bad_total;
        r.bad_start_count = bad_start_total;
        r.timeout_count   = timeout_total;
        report_queue.push_back(r);
    endtask

    // Handshakes are sampled at the falling edge, so the decision never races the DUT.
    task automatic send_word(input logic op, input logic [7:0] b);
        while (gaps_on && $urandom_range(99) < 23) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.op      <= op;
        in_ch.rx_byte <= b;
        do @(negedge i_clk); while (!in_ch.ready);
        @(posedge i_clk);
        predict_report(op, b);
        words_sent++;
    endtask

    task automatic send_tick();
        send_word(spd_pkg::OP_TICK, 8'($urandom_range(255)));
    endtask

    // Waits until every outstanding word has produced its report.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (report_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [spd_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            spd_pkg::CFG_START_HIGH: cfg_start_high = value[7:0];
            spd_pkg::CFG_START_LOW:  cfg_start_low  = value[7:0];
            spd_pkg::CFG_VERSION:    cfg_version    = value[7:0];
            spd_pkg::CFG_MAX_LENGTH: cfg_max_length = value[7:0];
            spd_pkg::CFG_TIMEOUT:    cfg_timeout    = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] sh, input logic [7:0] sl, input logic [7:0] ver,
                              input logic [7:0] maxl, input logic [15:0] tmo);
        settle();
        write_reg(spd_pkg::CFG_START_HIGH, {8'h00, sh});
        write_reg(spd_pkg::CFG_START_LOW, {8'h00, sl});
        write_reg(spd_pkg::CFG_VERSION, {8'h00, ver});
        write_reg(spd_pkg::CFG_MAX_LENGTH, {8'h00, maxl});
        write_reg(spd_pkg::CFG_TIMEOUT, tmo);
    endtask

    // Sends a complete frame; ticks may be slipped in before any byte.
    task automatic send_frame(input int len, input bit corrupt, input int tick_pct);
        logic [7:0]  hdr[4];
        logic [7:0]  b;
        logic [15:0] crc;
        crc = spd_pkg::CRC_SEED;
        hdr = '{cfg_start_high, cfg_start_low, cfg_version, 8'(len)};
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(99) < tick_pct) send_tick();
            send_word(spd_pkg::OP_BYTE, hdr[i]);
        end
        for (int i = 0; i < len; i++) begin
            b   = 8'($urandom_range(255));
            crc = crc_ccitt_step(crc, b);
            if ($urandom_range(99) < tick_pct) send_tick();
            send_word(spd_pkg::OP_BYTE, b);
        end
        if (corrupt) crc ^= 16'($urandom_range(1, 65535));
        if ($urandom_range(99) < tick_pct) send_tick();
        send_word(spd_pkg::OP_BYTE, crc[15:8]);
        if ($urandom_range(99) < tick_pct) send_tick();
        send_word(spd_pkg::OP_BYTE, crc[7:0]);
    endtask

    // A header that goes wrong at a random position.
    task automatic send_broken_header();
        logic [7:0] hdr[4];
        int         k;
        k   = $urandom_range(3);
        hdr = '{cfg_start_high, cfg_start_low, cfg_version, 8'h00};
        if (k == 3 && cfg_max_length != 8'hFF && $urandom_range(1))
            hdr[3] = 8'($urandom_range(cfg_max_length + 1, 255));
        else if (k < 3)
            hdr[k] = hdr[k] ^ 8'($urandom_range(1, 255));
        for (int i = 0; i <= k; i++) send_word(spd_pkg::OP_BYTE, hdr[i]);
    endtask

    task automatic test_good_frame();
        send_frame(1, 1'b0, 0);
    endtask

    task automatic test_start_mark();
        send_word(spd_pkg::OP_BYTE, 8'hFF);
        send_word(spd_pkg::OP_BYTE, cfg_start_high);
        send_word(spd_pkg::OP_BYTE, 8'h00);
    endtask

    task automatic test_header_checks();
        send_word(spd_pkg::OP_BYTE, cfg_start_high);
        send_word(spd_pkg::OP_BYTE, cfg_start_low);
        send_word(spd_pkg::OP_BYTE, ~cfg_version);
        send_word(spd_pkg::OP_BYTE, cfg_start_high);
        send_word(spd_pkg::OP_BYTE, cfg_start_low);
        send_word(spd_pkg::OP_BYTE, cfg_version);
        send_word(spd_pkg::OP_BYTE, 8'h00);
    endtask

    // A zero length limit written while a frame is open must reject its length byte.
    task automatic test_midframe_config();
        send_word(spd_pkg::OP_BYTE, cfg_start_high);
        send_word(spd_pkg::OP_BYTE, cfg_start_low);
        send_word(spd_pkg::OP_BYTE, cfg_version);
        settle();
        write_reg(spd_pkg::CFG_MAX_LENGTH, 16'd0);
        send_word(spd_pkg::OP_BYTE, 8'd1);
        settle();
        write_reg(spd_pkg::CFG_MAX_LENGTH, 16'(spd_pkg::RST_MAX_LENGTH));
    endtask

    task automatic test_crc_fail();
        send_frame(1, 1'b1, 0);
    endtask

    // A tick with the timer stopped does nothing; a zero timeout fires on the first tick.
    task automatic test_timeout();
        send_tick();
        settle();
        write_reg(spd_pkg::CFG_TIMEOUT, 16'd0);
        send_word(spd_pkg::OP_BYTE, cfg_start_high);
        send_tick();
        settle();
        write_reg(spd_pkg::CFG_TIMEOUT, spd_pkg::RST_TIMEOUT);
    endtask

    task automatic test_random_traffic(input int n_words);
        int target, r, len, lim;
        target = words_sent + n_words;
        while (words_sent < target) begin
            r = $urandom_range(99);
            if (r < 70) begin
                lim = (cfg_max_length == 8'd0) ? 12 :
                      ((cfg_max_length < 8'd12) ? int'(cfg_max_length) : 12);
                len = ($urandom_range(39) == 0) ? $urandom_range(1, 255) : $urandom_range(1, lim);
                send_frame(len, $urandom_range(99) < 15, $urandom_range(8));
            end else if (r < 80) begin
                send_broken_header();
            end else if (r < 90) begin
                repeat ($urandom_range(1, 4)) send_word(spd_pkg::OP_BYTE, 8'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(1, 6)) send_tick();
            end
        end
    endtask

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= !gaps_on || ($urandom_range(99) >= 23);
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
        if (exp !== act) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
            error_count++;
        end
    endtask

    always @(negedge i_clk) begin
        t_frame_report e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (report_queue.size() == 0) begin
                $display("%0t: unexpected report word, expected none, actual event %0d",
                         $time, out_ch.event_res);
                error_count++;
            end else begin
                e = report_queue.pop_front();
                check_field("event_res", 32'(e.event_res), 32'(out_ch.event_res));
                check_field("payload_byte", 32'(e.payload_byte), 32'(out_ch.payload_byte));
                check_field("byte_index", 32'(e.byte_index), 32'(out_ch.byte_index));
                check_field("packet_length", 32'(e.packet_length), 32'(out_ch.packet_length));
                check_field("good_count", e.good_count, out_ch.good_count);
                check_field("bad_count", e.bad_count, out_ch.bad_count);
                check_field("bad_start_count", e.bad_start_count, out_ch.bad_start_count);
                check_field("timeout_count", e.timeout_count, out_ch.timeout_count);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int waited;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_wdata   = '0;
        in_ch.valid   = 1'b0;
        in_ch.op      = spd_pkg::OP_BYTE;
        in_ch.rx_byte = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_good_frame();
        test_start_mark();
        test_header_checks();
        test_midframe_config();
        test_crc_fail();
        test_timeout();

        test_random_traffic(390);
        // No gaps on either side during this setting.
        settle();
        gaps_on = 1'b0;
        set_config(8'hFF, 8'h00, 8'hFF, 8'd1, 16'hFFFF);
        test_random_traffic(390);
        settle();
        gaps_on = 1'b1;
        set_config(8'h00, 8'hFF, 8'h00, 8'hFF, 16'd1);
        test_random_traffic(390);
        set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(1, 40)), 16'($urandom_range(3, 20)));
        test_random_traffic(390);

        in_ch.valid <= 1'b0;
        waited = 0;
        while (report_queue.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        if (report_queue.size() != 0) begin
            $display("%0t: %0d expected report words never arrived", $time, report_queue.size());
            error_count++;
        end
        repeat (5) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
